/* sv/pds_pkg.sv */
// Package for the proper divisor sum classifier.
// Holds the field widths, saturation limits, item structs and the control state type.
// No dependencies.
package pds_pkg;

    localparam int VALUE_W = 24;
    localparam int COUNT_W = 12;
    localparam int SUM_W   = 27;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};

    typedef struct packed {
        logic [VALUE_W-1:0] value;
    } value_item_t;

    typedef struct packed {
        logic [COUNT_W-1:0] divisor_count;
        logic [SUM_W-1:0]   divisor_sum;
        logic               is_perfect;
        logic               is_amicable;
    } result_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_DIVIDE,
        ST_PASS_END,
        ST_FINISH
    } state_t;

endpackage

/* sv/pds_stream_if.sv */
// Valid/ready channel for the proper divisor sum classifier.
// The payload type is chosen per instance; typically a struct from pds_pkg.
interface pds_stream_if #(
    parameter type payload_t = logic
) ();

    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);

endinterface

/* sv/pds_divider.sv */
// Bit-serial restoring divider: one quotient bit per cycle, MSB first.
// Gives quotient and remainder of an unsigned dividend by an unsigned divisor.
// No package dependencies.
module pds_divider #(
    parameter int W  = 27,
    parameter int DW = 15
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [W-1:0]  dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [W-1:0]  quotient,
    output logic [DW-1:0] remainder
);

    localparam int CW = (W > 1) ? $clog2(W) : 1;

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW-1:0] dvs_reg, dvs_next;
    logic [DW:0]   trial;
    logic          fits;

    // Dividend shifts out of the top of quo_reg while quotient bits enter at the bottom
    assign trial = {rem_reg, quo_reg[W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[W-2:0], fits};
            rem_next = fits ? DW'(trial - {1'b0, dvs_reg}) : DW'(trial);
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* sv/proper_divisor_sum_classifier.sv */
// Aliquot sum classifier: for each n it returns the proper divisor count, the divisor sum
// s(n) and perfect / amicable flags. One item at a time; a trial divisor i runs while
// i*i < m, and each trial is one bit-serial division plus the ST_TEST control state. The
// first pass runs on n and a second on s(n) when 2 <= s(n) != n.
// The divider is the only arithmetic loop.
// Depends on pds_pkg, pds_stream_if and pds_divider.
module proper_divisor_sum_classifier #(
    parameter int VALUE_BITS = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    pds_stream_if.sink    request,
    pds_stream_if.source  result
);

    localparam int NB  = VALUE_BITS;
    localparam int SW  = VALUE_BITS + 3;     // s(n) < 8n over the parameter range
    localparam int IW  = (SW + 1) / 2 + 1;   // trial divisor reaches ceil(sqrt(m))
    localparam int SQW = 2 * IW;
    localparam int AW  = SW + 3;             // second-pass sums grow past SW

    pds_pkg::state_t state_reg, state_next;

    logic [NB-1:0]              n_reg, n_next;
    logic [SW-1:0]              m_reg, m_next;
    logic [SW-1:0]              partner_reg, partner_next;
    logic [IW-1:0]              i_reg, i_next;
    logic [SQW-1:0]             sq_reg, sq_next;
    logic [AW-1:0]              acc_reg, acc_next;
    logic [pds_pkg::COUNT_W-1:0] cnt_reg, cnt_next;
    logic                       phase_reg, phase_next;
    logic                       perfect_reg, perfect_next;
    logic                       amicable_reg, amicable_next;
    logic                       out_valid_reg, out_valid_next;
    pds_pkg::result_item_t      out_reg, out_next;

    logic                       div_start;
    logic                       div_done;
    logic [SW-1:0]              div_quo;
    logic [IW-1:0]              div_rem;

    logic                       accept;
    logic                       below;
    logic                       square_hit;
    logic                       out_free;
    logic [pds_pkg::COUNT_W:0]  cnt_plus1;
    logic [pds_pkg::COUNT_W:0]  cnt_plus2;
    logic [pds_pkg::COUNT_W-1:0] cnt_sat1;
    logic [pds_pkg::COUNT_W-1:0] cnt_sat2;
    logic [pds_pkg::SUM_W-1:0]  sum_sat;
    logic                       go_second;

    pds_divider #(
        .W  (SW),
        .DW (IW)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (m_reg),
        .divisor   (i_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign accept     = request.valid && request.ready;
    assign below      = sq_reg < SQW'(m_reg);
    assign square_hit = (i_reg > IW'(1)) && (sq_reg == SQW'(m_reg));
    assign out_free   = !out_valid_reg || result.ready;
    assign go_second  = (AW'(n_reg) != acc_reg) && (acc_reg >= AW'(2));

    assign cnt_plus1 = {1'b0, cnt_reg} + (pds_pkg::COUNT_W + 1)'(1);
    assign cnt_plus2 = {1'b0, cnt_reg} + (pds_pkg::COUNT_W + 1)'(2);
    assign cnt_sat1  = (cnt_plus1 > {1'b0, pds_pkg::COUNT_MAX}) ? pds_pkg::COUNT_MAX
                                                                 : cnt_plus1[pds_pkg::COUNT_W-1:0];
    assign cnt_sat2  = (cnt_plus2 > {1'b0, pds_pkg::COUNT_MAX}) ? pds_pkg::COUNT_MAX
                                                                 : cnt_plus2[pds_pkg::COUNT_W-1:0];
    assign sum_sat   = (AW'(partner_reg) > AW'(pds_pkg::SUM_MAX)) ? pds_pkg::SUM_MAX
                                                                   : pds_pkg::SUM_W'(partner_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            pds_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = pds_pkg::ST_TEST;
            end
            pds_pkg::ST_TEST:
            begin
                state_next = below ? pds_pkg::ST_DIVIDE : pds_pkg::ST_PASS_END;
            end
            pds_pkg::ST_DIVIDE:
            begin
                if (div_done)
                    state_next = pds_pkg::ST_TEST;
            end
            pds_pkg::ST_PASS_END:
            begin
                if (!phase_reg && go_second)
                    state_next = pds_pkg::ST_TEST;
                else
                    state_next = pds_pkg::ST_FINISH;
            end
            pds_pkg::ST_FINISH:
            begin
                if (out_free)
                    state_next = pds_pkg::ST_IDLE;
            end
            default:
                state_next = pds_pkg::ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb
    begin
        n_next         = n_reg;
        m_next         = m_reg;
        partner_next   = partner_reg;
        i_next         = i_reg;
        sq_next        = sq_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        perfect_next   = perfect_reg;
        amicable_next  = amicable_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !result.ready;
        div_start      = 1'b0;

        unique case (state_reg)
            pds_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    n_next        = NB'(request.data.value);
                    m_next        = SW'(NB'(request.data.value));
                    i_next        = IW'(1);
                    sq_next       = SQW'(1);
                    acc_next      = '0;
                    cnt_next      = '0;
                    phase_next    = 1'b0;
                    perfect_next  = 1'b0;
                    amicable_next = 1'b0;
                end
            end
            pds_pkg::ST_TEST:
            begin
                if (below)
                    div_start = 1'b1;
                else if (square_hit)
                begin
                    acc_next = acc_reg + AW'(i_reg);
                    if (!phase_reg)
                        cnt_next = cnt_sat1;
                end
            end
            pds_pkg::ST_DIVIDE:
            begin
                if (div_done)
                begin
                    if (div_rem == '0)
                    begin
                        // Divisor i, and its cofactor unless it is m itself
                        if (i_reg > IW'(1))
                        begin
                            acc_next = acc_reg + AW'(i_reg) + AW'(div_quo);
                            if (!phase_reg)
                                cnt_next = cnt_sat2;
                        end
                        else
                        begin
                            acc_next = acc_reg + AW'(i_reg);
                            if (!phase_reg)
                                cnt_next = cnt_sat1;
                        end
                    end
                    // Advance i and keep sq = i*i
                    i_next  = i_reg + IW'(1);
                    sq_next = sq_reg + SQW'({i_reg, 1'b1});
                end
            end
            pds_pkg::ST_PASS_END:
            begin
                if (!phase_reg)
                begin
                    partner_next = SW'(acc_reg);
                    perfect_next = (n_reg >= NB'(2)) && (acc_reg == AW'(n_reg));
                    if (go_second)
                    begin
                        phase_next = 1'b1;
                        m_next     = SW'(acc_reg);
                        i_next     = IW'(1);
                        sq_next    = SQW'(1);
                        acc_next   = '0;
                    end
                end
                else
                begin
                    amicable_next = acc_reg == AW'(n_reg);
                    phase_next    = 1'b0;
                end
            end
            pds_pkg::ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next         = 1'b1;
                    out_next.divisor_count = cnt_reg;
                    out_next.divisor_sum   = sum_sat;
                    out_next.is_perfect    = perfect_reg;
                    out_next.is_amicable   = amicable_reg;
                end
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= pds_pkg::ST_IDLE;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            cnt_reg       <= '0;
            acc_reg       <= '0;
            partner_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            cnt_reg       <= cnt_next;
            acc_reg       <= acc_next;
            partner_reg   <= partner_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg        <= n_next;
        m_reg        <= m_next;
        sq_reg       <= sq_next;
        perfect_reg  <= perfect_next;
        amicable_reg <= amicable_next;
        out_reg      <= out_next;
    end

    assign request.ready = state_reg == pds_pkg::ST_IDLE;
    assign result.valid  = out_valid_reg;
    assign result.data   = out_reg;

endmodule
